>>> rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants of the fault record table.
// ----------------------------------------------------------------------------
package frt_pkg;

	// default table depth
	localparam int SLOTS_DEF = 16;

	// field widths
	localparam int KIND_W   = 3;
	localparam int KEY_W    = 16;
	localparam int TIME_W   = 32;
	localparam int ID_W     = 16;
	localparam int SLOT_W   = 4;
	localparam int ACTION_W = 2;

	// reset value of the stale limit
	localparam logic [TIME_W-1:0] STALE_RESET = 32'd5000;

	// highest id, never evictable
	localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;

	// result action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_UPDATE = 2'd0,
		ACT_NEW    = 2'd1,
		ACT_STALE  = 2'd2
	} action_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_OUT
	} state_t;

	// one stored record
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  source;
		logic [KEY_W-1:0]  site;
		logic [TIME_W-1:0] last;
	} entry_t;

	// summary of one pass over the table
	typedef struct packed {
		logic              match_found;
		logic [ID_W-1:0]   match_id;
		logic [TIME_W-1:0] match_last;
		logic              free_found;
		logic              low_found;
		logic [ID_W-1:0]   low_id;
	} scan_res_t;

endpackage

>>> rtl/frt_store.sv
// ----------------------------------------------------------------------------
// frt_store
// Record memory, one read and one write a cycle, registered read data.
// Per-entry valid bits make unwritten entries read as free.
// ----------------------------------------------------------------------------
module frt_store #(
	parameter int SLOTS = frt_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output frt_pkg::entry_t            rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(SLOTS)-1:0]   wr_addr,
	input  frt_pkg::entry_t            wr_data
);
	import frt_pkg::*;

	entry_t           mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	entry_t           rdata_q;
	logic             rvld_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	// an entry never written reads with id zero
	always_comb begin
		rd_data = rdata_q;
		if (!rvld_q) begin
			rd_data.id = '0;
		end
	end

endmodule

>>> rtl/frt_scan.sv
// ----------------------------------------------------------------------------
// frt_scan
// Compare unit applied to one entry per cycle: tracks best match,
// first free slot and lowest id over a table pass.
// ----------------------------------------------------------------------------
module frt_scan #(
	parameter int SLOTS = frt_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              en,
	input  logic [$clog2(SLOTS)-1:0]          idx,
	input  frt_pkg::entry_t                   ent,
	input  logic [frt_pkg::KIND_W-1:0]        key_kind,
	input  logic [frt_pkg::KEY_W-1:0]         key_source,
	input  logic [frt_pkg::KEY_W-1:0]         key_site,
	output frt_pkg::scan_res_t                res,
	output logic [$clog2(SLOTS)-1:0]          match_slot,
	output logic [$clog2(SLOTS)-1:0]          free_slot,
	output logic [$clog2(SLOTS)-1:0]          low_slot
);
	import frt_pkg::*;

	localparam int IW = $clog2(SLOTS);

	logic [ID_W-1:0]   best_q;
	logic [TIME_W-1:0] best_last_q;
	logic [IW-1:0]     best_slot_q;
	logic              free_q;
	logic [IW-1:0]     free_slot_q;
	logic              low_q;
	logic [ID_W-1:0]   low_id_q;
	logic [IW-1:0]     low_slot_q;
	logic              key_eq;
	logic              take_match;
	logic              take_free;
	logic              take_low;

	// per-entry compares
	always_comb begin
		key_eq     = (ent.kind == key_kind) && (ent.source == key_source) &&
		             (ent.site == key_site);
		take_match = en && key_eq && (ent.id > best_q);
		take_free  = en && !free_q && (ent.id == '0);
		take_low   = en && (ent.id < low_id_q);
	end

	// running results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			free_q   <= 1'b0;
			low_q    <= 1'b0;
			low_id_q <= ID_MAX;
		end else if (clr) begin
			best_q   <= '0;
			free_q   <= 1'b0;
			low_q    <= 1'b0;
			low_id_q <= ID_MAX;
		end else begin
			if (take_match) begin
				best_q <= ent.id;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
			if (take_low) begin
				low_q    <= 1'b1;
				low_id_q <= ent.id;
			end
		end
	end

	// slot and time payload
	always_ff @(posedge clk) begin
		if (take_match) begin
			best_last_q <= ent.last;
			best_slot_q <= idx;
		end
		if (take_free) begin
			free_slot_q <= idx;
		end
		if (take_low) begin
			low_slot_q <= idx;
		end
	end

	always_comb begin
		res.match_found = (best_q != '0);
		res.match_id    = best_q;
		res.match_last  = best_last_q;
		res.free_found  = free_q;
		res.low_found   = low_q;
		res.low_id      = low_id_q;
	end

	assign match_slot = best_slot_q;
	assign free_slot  = free_slot_q;
	assign low_slot   = low_slot_q;

endmodule

>>> rtl/fault_record_table_top.sv
// An accepted item walks the table, then passes the drain and decide steps
// before its result is offered; a new item is taken only once that result
// is taken, and each table walk runs through the single memory port.
// Reset: asynchronous, active low; the table reads empty at once through
// per-entry valid bits, no clearing pass; next id is 1, stale limit 5000.
// ----------------------------------------------------------------------------
// fault_record_table_top
// Fault record table: match, refresh, create and evict records, walking
// the table one entry per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
module fault_record_table_top #(
	parameter int SLOTS = frt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // source_key[15:0], site_key[31:16], now_ms[63:32]
	input  logic [2:0]  s_tuser,   // fault_kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // slot[3:0], record_id[19:4], evicted[20],
	                               // evicted_id[36:21], zero[39:37]
	output logic [1:0]  m_tuser,   // action[1:0]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata  // stale_time_ms
);
	import frt_pkg::*;

	localparam int IW = $clog2(SLOTS);

	state_t              state_q;
	state_t              state_d;
	logic [IW-1:0]       idx_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    src_q;
	logic [KEY_W-1:0]    site_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   stale_q;
	logic [ID_W-1:0]     next_id_q;
	action_t             action_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ID_W-1:0]     rec_id_q;
	logic                evicted_q;
	logic [ID_W-1:0]     evid_q;

	logic                rd_en;
	logic                scan_clr;
	logic                decide;
	logic                accept;
	logic                idx_last;
	entry_t              rd_data;
	entry_t              wr_data;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	scan_res_t           res;
	logic [IW-1:0]       match_slot;
	logic [IW-1:0]       free_slot;
	logic [IW-1:0]       low_slot;

	logic [TIME_W-1:0]   age;
	logic                stale;
	logic                hit;
	logic                dst_ok;
	logic [IW-1:0]       dst_idx;
	logic [IW-1:0]       res_idx;
	logic [IW+SLOT_W-1:0] res_idx_ext;
	action_t             action_d;

	// record memory
	frt_store #(.SLOTS(SLOTS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// shared compare unit
	frt_scan #(.SLOTS(SLOTS)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (scan_clr),
		.en         (rd_vld_s1),
		.idx        (rd_idx_s1),
		.ent        (rd_data),
		.key_kind   (kind_q),
		.key_source (src_q),
		.key_site   (site_q),
		.res        (res),
		.match_slot (match_slot),
		.free_slot  (free_slot),
		.low_slot   (low_slot)
	);

	assign accept   = s_tvalid && s_tready;
	assign idx_last = (idx_q == IW'(SLOTS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN:   if (idx_last) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_OUT;
			ST_OUT:    if (m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		rd_en    = 1'b0;
		scan_clr = 1'b0;
		decide   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				scan_clr = 1'b1;
			end
			ST_SCAN:   rd_en    = 1'b1;
			ST_DRAIN:  ;
			ST_DECIDE: decide   = 1'b1;
			ST_OUT:    m_tvalid = 1'b1;
			default:   ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			stale_q   <= STALE_RESET;
			next_id_q <= ID_W'(1);
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cfg_we) begin
				stale_q <= cfg_wdata;
			end
			if (decide && !hit) begin
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	// item capture and read index pipeline
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			kind_q <= s_tuser;
			src_q  <= s_tdata[15:0];
			site_q <= s_tdata[31:16];
			now_q  <= s_tdata[63:32];
		end
	end

	// stale check and slot choice
	always_comb begin
		age     = now_q - res.match_last;
		stale   = (res.match_last < now_q) && (age > stale_q);
		hit     = res.match_found && !stale;
		dst_ok  = res.free_found || res.low_found;
		dst_idx = res.free_found ? free_slot : low_slot;

		wr_addr        = hit ? match_slot : dst_idx;
		wr_en          = decide && (hit || dst_ok);
		wr_data.id     = hit ? res.match_id : next_id_q;
		wr_data.kind   = kind_q;
		wr_data.source = src_q;
		wr_data.site   = site_q;
		wr_data.last   = now_q;

		if (hit) begin
			action_d = ACT_UPDATE;
		end else if (res.match_found) begin
			action_d = ACT_STALE;
		end else begin
			action_d = ACT_NEW;
		end

		if (hit) begin
			res_idx = match_slot;
		end else if (dst_ok) begin
			res_idx = dst_idx;
		end else begin
			res_idx = '0;
		end
		res_idx_ext = {{SLOT_W{1'b0}}, res_idx};
	end

	// result register
	always_ff @(posedge clk) begin
		if (decide) begin
			action_q  <= action_d;
			slot_q    <= res_idx_ext[SLOT_W-1:0];
			rec_id_q  <= hit ? res.match_id : next_id_q;
			evicted_q <= !hit && !res.free_found && res.low_found;
			evid_q    <= (!hit && !res.free_found && res.low_found) ? res.low_id : '0;
		end
	end

	assign m_tdata = {3'b000, evid_q, evicted_q, rec_id_q, slot_q};
	assign m_tuser = action_q;

`ifndef SYNTH
	// input and output sides are never open together
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	// an accepted item starts a table walk
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && (idx_q == '0))
		else $error("table walk did not start after accept");

	// the id counter moves only in the decide step, where a new id is given out
	a_id_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DECIDE) |=> $stable(next_id_q))
		else $error("next id changed outside the decide step");

	// no table write outside the decide step
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_DECIDE))
		else $error("table written outside the decide step");
`endif

endmodule

>>> tb/tb_fault_record_table_top.sv
// ----------------------------------------------------------------------------
// tb_fault_record_table_top
// Self-checking bench for the fault record table. Fault reports go in on the
// slave stream, and a behavioral copy of the table works out the outcome of
// each accepted report. The outcomes on the master stream are checked in
// order. Directed, stale limit sweep, output backpressure and eviction churn tests.
// ----------------------------------------------------------------------------
module tb_fault_record_table_top;
	import frt_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int POOL_SIZE  = 24;
	localparam int WD_LIMIT   = 4000;
	localparam int HOLD_LEN   = 300;
	localparam int SWEEP_ITEMS = 170;

	// one fault report
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  source;
		logic [KEY_W-1:0]  site;
		logic [TIME_W-1:0] now;
	} report_t;

	// one table outcome
	typedef struct packed {
		action_t           action;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   record_id;
		logic              evicted;
		logic [ID_W-1:0]   evicted_id;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // source_key[15:0], site_key[31:16], now_ms[63:32]
	logic [2:0]  s_tuser;   // fault_kind[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // slot[3:0], record_id[19:4], evicted[20],
	                        // evicted_id[36:21], zero[39:37]
	logic [1:0]  m_tuser;   // action[1:0]
	logic        cfg_we;
	logic [31:0] cfg_wdata; // stale_time_ms

	// table copy kept by the bench
	logic [ID_W-1:0]   rec_id     [SLOTS];
	logic [KIND_W-1:0] rec_kind   [SLOTS];
	logic [KEY_W-1:0]  rec_source [SLOTS];
	logic [KEY_W-1:0]  rec_site   [SLOTS];
	logic [TIME_W-1:0] rec_last   [SLOTS];
	logic [ID_W-1:0]   next_rec_id;
	logic [TIME_W-1:0] stale_limit;

	outcome_t          pending_outcomes[$];
	report_t           fault_pool[POOL_SIZE];
	logic [TIME_W-1:0] report_clock;

	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;
	int rx_hold_cycles = 0;

	int mismatches  = 0;
	int n_reports   = 0;
	int n_results   = 0;
	int n_refreshed = 0;
	int n_created   = 0;
	int n_replaced  = 0;
	int n_evictions = 0;
	int n_limits    = 0;
	int idle_cycles = 0;

	fault_record_table_top #(.SLOTS(SLOTS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// random idle length, mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(12, 80);
	endfunction

	// report time moves mostly forward, sometimes far, sometimes back
	function automatic logic [TIME_W-1:0] advance_clock(input logic [TIME_W-1:0] t);
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return t + $urandom_range(0, 200);
		if (r < 80)
			return t + $urandom_range(0, 8000);
		if (r < 92)
			return t + $urandom;
		return t - $urandom_range(1, 3000);
	endfunction

	// apply one report to the table copy and return its outcome
	function automatic outcome_t log_fault(input report_t r);
		outcome_t o;
		int hit;
		int dst;
		int victim;
		logic [ID_W-1:0] best;
		logic [ID_W-1:0] low;
		logic [TIME_W-1:0] last;
		o = '0;
		hit = -1;
		best = '0;
		// newest matching record, free entries never match
		for (int i = 0; i < SLOTS; i++) begin
			if (rec_kind[i] == r.kind && rec_source[i] == r.source &&
			    rec_site[i] == r.site && rec_id[i] > best) begin
				hit = i;
				best = rec_id[i];
			end
		end
		if (hit >= 0) begin
			last = rec_last[hit];
			if (!(last < r.now && (r.now - last) > stale_limit)) begin
				rec_last[hit] = r.now;
				o.action = ACT_UPDATE;
				o.slot = SLOT_W'(hit);
				o.record_id = rec_id[hit];
				return o;
			end
			o.action = ACT_STALE;
		end else begin
			o.action = ACT_NEW;
		end
		// new record takes the next id, which wraps through zero
		o.record_id = next_rec_id;
		next_rec_id = next_rec_id + 1'b1;
		dst = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (rec_id[i] == '0 && dst < 0)
				dst = i;
		end
		// table full: evict the lowest id, all-max table has no victim
		if (dst < 0) begin
			low = ID_MAX;
			victim = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (rec_id[i] < low) begin
					low = rec_id[i];
					victim = i;
				end
			end
			if (victim >= 0) begin
				o.evicted = 1'b1;
				o.evicted_id = low;
				dst = victim;
			end
		end
		if (dst >= 0) begin
			rec_id[dst] = o.record_id;
			rec_kind[dst] = r.kind;
			rec_source[dst] = r.source;
			rec_site[dst] = r.site;
			rec_last[dst] = r.now;
			o.slot = SLOT_W'(dst);
		end
		return o;
	endfunction

	// offer one report and log its outcome once accepted
	task automatic send_report(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] source,
			input logic [KEY_W-1:0] site, input logic [TIME_W-1:0] now);
		report_t r;
		outcome_t o;
		int gap;
		r.kind = kind;
		r.source = source;
		r.site = site;
		r.now = now;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, site, source};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		o = log_fault(r);
		pending_outcomes.push_back(o);
		n_reports++;
		case (o.action)
			ACT_UPDATE: n_refreshed++;
			ACT_NEW:    n_created++;
			default:    n_replaced++;
		endcase
		if (o.evicted)
			n_evictions++;
	endtask

	// stop offering, let all outcomes arrive and the block settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
	endtask

	task automatic set_stale_limit(input logic [TIME_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		stale_limit = value;
		n_limits++;
	endtask

	// mostly repeat offenders from the pool, some one-off faults
	task automatic send_random_reports(input int count);
		report_t r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 80) begin
				r = fault_pool[$urandom_range(POOL_SIZE - 1)];
			end else begin
				r.kind = KIND_W'($urandom);
				r.source = KEY_W'($urandom);
				r.site = KEY_W'($urandom);
			end
			report_clock = advance_clock(report_clock);
			send_report(r.kind, r.source, r.site, report_clock);
		end
	endtask

	// refresh, stale replace, time wrap, highest id match, fill and evict
	task automatic test_directed();
		send_report(3'd0, 16'h0000, 16'h0000, 32'd0);
		send_report(3'd0, 16'h0000, 16'h0000, 32'd5000);
		send_report(3'd0, 16'h0000, 16'h0000, 32'd10001);
		send_report(3'd0, 16'h0000, 16'h0000, 32'd10002);
		send_report(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_report(3'd7, 16'hFFFF, 16'hFFFF, 32'd5);
		send_report(3'd7, 16'hFFFF, 16'hFFFF, 32'd5);
		for (int i = 0; i < 13; i++)
			send_report(KIND_W'(i), KEY_W'(16'h1000 + i), KEY_W'(16'h8000 - i),
				32'd20000 + i);
		send_report(3'd5, 16'hA5A5, 16'h5A5A, 32'd30000);
		send_report(3'd2, 16'h00FF, 16'hFF00, 32'd30001);
		send_report(3'd0, 16'h0000, 16'h0000, 32'd30002);
	endtask

	// random traffic under several stale limits, extremes included
	task automatic test_stale_sweep();
		logic [TIME_W-1:0] limits[5];
		limits[0] = '0;
		limits[1] = '1;
		limits[2] = STALE_RESET;
		limits[3] = $urandom_range(50, 3000);
		limits[4] = 32'd1;
		for (int ph = 0; ph < 5; ph++) begin
			set_stale_limit(limits[ph]);
			for (int k = 0; k < POOL_SIZE; k++) begin
				fault_pool[k].kind = KIND_W'($urandom);
				fault_pool[k].source = KEY_W'($urandom);
				fault_pool[k].site = KEY_W'($urandom);
			end
			tx_gaps_on = (ph != 1);
			rx_stalls_on = (ph != 2);
			send_random_reports(SWEEP_ITEMS);
		end
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// receiver holds off while reports keep coming, block must stall input
	task automatic test_output_backpressure();
		tx_gaps_on = 1'b0;
		rx_hold_cycles = HOLD_LEN;
		send_random_reports(40);
		tx_gaps_on = 1'b1;
	endtask

	// new faults back to back into a full table, each pushing out the lowest id
	task automatic test_eviction_churn();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		for (int i = 0; i < 2 * SLOTS; i++)
			send_report(KIND_W'(i), KEY_W'(16'h7000 + i), 16'h1C3D, 32'h4000_0000 + i);
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		send_random_reports(30);
	endtask

	// receiver: random stalls, long hold on request
	initial begin
		int n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				n = rx_stalls_on ? pick_gap() : 0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// compare each outcome with the oldest one logged
	always @(posedge clk) begin
		outcome_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected outcome: action %0d tdata %h", m_tuser, m_tdata);
			end else begin
				want = pending_outcomes.pop_front();
				if (m_tuser != want.action || m_tdata[3:0] != want.slot ||
				    m_tdata[19:4] != want.record_id || m_tdata[20] != want.evicted ||
				    m_tdata[36:21] != want.evicted_id) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("outcome %0d expected: action %0d slot %0d id %0d evict %0d/%0d",
							n_results, want.action, want.slot, want.record_id,
							want.evicted, want.evicted_id);
						$display("outcome %0d actual:   action %0d slot %0d id %0d evict %0d/%0d",
							n_results, m_tuser, m_tdata[3:0], m_tdata[19:4],
							m_tdata[20], m_tdata[36:21]);
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d outcomes outstanding",
				idle_cycles, pending_outcomes.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		for (int i = 0; i < SLOTS; i++) begin
			rec_id[i] = '0;
			rec_kind[i] = '0;
			rec_source[i] = '0;
			rec_site[i] = '0;
			rec_last[i] = '0;
		end
		next_rec_id = 16'd1;
		stale_limit = STALE_RESET;
		report_clock = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stale_sweep();
		test_output_backpressure();
		test_eviction_churn();
		wait_drained();
		$display("covered %0d reports: %0d refreshed, %0d new, %0d stale replaced, %0d evicted",
			n_reports, n_refreshed, n_created, n_replaced, n_evictions);
		$display("%0d outcomes checked over %0d stale limits, output hold and eviction churn",
			n_results, n_limits);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
